### sv/dbrr_pkg.sv
// ============================================================================
// dbrr_pkg - shared types and constants for the DNS response rewriter
// Beat payload structs, byte lane count, APB sizing and the answer tail bytes.
// ============================================================================
package dbrr_pkg;

    localparam int LANES        = 8;
    localparam int NAME_MAX_DEF = 256;
    localparam int ADDR_W       = 3;
    localparam int PDATA_W      = 32;
    localparam int TAIL_LEN     = 14;

    localparam logic [3:0] RCODE_NXDOMAIN = 4'd3;
    localparam logic [3:0] RCODE_REFUSED  = 4'd5;
    localparam logic [3:0] RCODE_CLEARED  = 4'd0;

    typedef enum logic [1:0] {
        MODE_NXDOMAIN = 2'd0,
        MODE_REFUSED  = 2'd1,
        MODE_FAKE     = 2'd2,
        MODE_CLEAR    = 2'd3
    } t_mode;

    // Register index, decoded from paddr[2]
    typedef enum logic {
        REG_MODE = 1'b0,
        REG_ADDR = 1'b1
    } t_reg;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_word;
    } t_req;

    typedef struct packed {
        logic [63:0] out_word;
        logic [3:0]  out_count;
        logic        out_last;
        logic        name_error;
    } t_rsp;

    // Answer record after the name: type A, class IN, TTL 3600, RDLENGTH 4, IPv4
    function automatic t_byte tail_byte(input logic [3:0] idx, input logic [31:0] addr);
        t_byte b;
        b = 8'h00;
        case (idx)
            4'd1:    b = 8'h01;
            4'd3:    b = 8'h01;
            4'd6:    b = 8'h0E;
            4'd7:    b = 8'h10;
            4'd9:    b = 8'h04;
            4'd10:   b = addr[31:24];
            4'd11:   b = addr[23:16];
            4'd12:   b = addr[15:8];
            4'd13:   b = addr[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### sv/dns_block_response_rewriter.sv
// ============================================================================
// dns_block_response_rewriter - DNS sinkhole response rewriter
// Passes request beats through with RCODE/ANCOUNT edits, captures the query
// name into a banked store and appends an A record in fake-address mode.
// ============================================================================
// Timing: a passed beat is in the output register the cycle after it is taken;
// an appended answer reads the name store in S_READ, then S_EMIT loads a beat.
// Throughput: one request beat per cycle unless the output stalls; each appended
// beat repeats S_READ then S_EMIT, and the input stalls until the final one is out.
// Reset: synchronous, clears mode, address, position and name counters; the
// name store is not cleared and is only read where written by this request.
module dns_block_response_rewriter #(
    parameter int NAME_MAX = dbrr_pkg::NAME_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  dbrr_pkg::t_req                i_req,
    output logic                          o_valid,
    input  logic                          i_stall,
    output dbrr_pkg::t_rsp                o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbrr_pkg::ADDR_W-1:0]   paddr,
    input  logic [dbrr_pkg::PDATA_W-1:0]  pwdata,
    output logic [dbrr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int LANES = dbrr_pkg::LANES;
    localparam int LEN_W = $clog2(NAME_MAX + 1);
    localparam int ROWS  = (NAME_MAX + 7) / 8;
    localparam int ROW_W = $clog2(ROWS);
    localparam int TOT_W = $clog2(NAME_MAX + LANES + dbrr_pkg::TAIL_LEN + 1);
    localparam int Q_W   = TOT_W + 1;
    localparam int WRD_W = $clog2((NAME_MAX + LANES + dbrr_pkg::TAIL_LEN + 7) / 8);

    typedef enum logic [1:0] {
        S_PASS,
        S_READ,
        S_EMIT
    } t_state;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [1:0]     r_mode;
    logic [31:0]    r_addr;
    logic           cfg_wr;
    dbrr_pkg::t_reg cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = dbrr_pkg::t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dbrr_pkg::MODE_NXDOMAIN;
            r_addr <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                dbrr_pkg::REG_MODE: r_mode <= pwdata[1:0];
                dbrr_pkg::REG_ADDR: r_addr <= pwdata;
                default:            r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            dbrr_pkg::REG_MODE: prdata = {30'd0, r_mode};
            dbrr_pkg::REG_ADDR: prdata = r_addr;
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------------
    t_state                r_state;
    logic [15:0]           r_pos;
    logic [LEN_W-1:0]      r_len;
    logic                  r_done;
    logic                  r_out_valid;
    dbrr_pkg::t_rsp        r_out;
    dbrr_pkg::t_byte [LANES-1:0] r_held;
    logic [3:0]            r_n0;
    logic [LEN_W-1:0]      r_alen;
    logic [TOT_W-1:0]      r_total;
    logic [WRD_W-1:0]      r_word;

    logic out_free;
    logic acc;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_PASS) || !out_free;
    assign acc      = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_out;

    // ------------------------------------------------------------------------
    // Request beat: header edits and name capture
    // ------------------------------------------------------------------------
    logic [3:0]                         cnt;
    dbrr_pkg::t_byte [LANES-1:0]        beat_bytes;
    logic [LEN_W-1:0]                   n_len;
    logic                               n_done;
    logic [15:0]                        n_pos;
    logic [16:0]                        pos_sum;
    logic [LANES-1:0]                   wr_en;
    logic [LANES-1:0][ROW_W-1:0]        wr_row;
    dbrr_pkg::t_byte [LANES-1:0]        wr_data;
    logic [3:0]                         rcode;

    always_comb begin
        if (i_req.byte_count == 4'd0) begin
            cnt = 4'd1;
        end else if (i_req.byte_count > 4'd8) begin
            cnt = 4'd8;
        end else begin
            cnt = i_req.byte_count;
        end
        pos_sum = {1'b0, r_pos} + 17'(cnt);
        n_pos   = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
    end

    always_comb begin
        case (r_mode)
            dbrr_pkg::MODE_NXDOMAIN: rcode = dbrr_pkg::RCODE_NXDOMAIN;
            dbrr_pkg::MODE_REFUSED:  rcode = dbrr_pkg::RCODE_REFUSED;
            default:                 rcode = dbrr_pkg::RCODE_CLEARED;
        endcase
    end

    // Capture is a short serial chain: at most eight bytes, each may end it
    always_comb begin
        logic [16:0]     p;
        dbrr_pkg::t_byte b;
        n_len   = r_len;
        n_done  = r_done;
        wr_en   = '0;
        wr_row  = '0;
        wr_data = '0;
        for (int i = 0; i < LANES; i++) begin
            p = {1'b0, r_pos} + 17'(i);
            b = i_req.data_word[8*i +: 8];
            if (4'(i) < cnt) begin
                if (p == 17'd3) begin
                    b = {b[7:4], rcode};
                end else if (p == 17'd6 && r_mode == dbrr_pkg::MODE_FAKE) begin
                    b = 8'h00;
                end else if (p == 17'd7 && r_mode == dbrr_pkg::MODE_FAKE) begin
                    b = 8'h01;
                end
                if (p >= 17'd12 && !n_done && n_len < LEN_W'(NAME_MAX)) begin
                    wr_en[n_len[2:0]]   = 1'b1;
                    wr_row[n_len[2:0]]  = n_len[ROW_W+2:3];
                    wr_data[n_len[2:0]] = b;
                    n_len = n_len + LEN_W'(1);
                    if (b == 8'h00) begin
                        n_done = 1'b1;
                    end
                end
                beat_bytes[i] = b;
            end else begin
                beat_bytes[i] = 8'h00;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Name store and append readout
    // ------------------------------------------------------------------------
    logic [LANES-1:0][ROW_W-1:0]  rd_row;
    dbrr_pkg::t_byte [LANES-1:0]  rd_data;
    logic [LANES-1:0]             store_wr;

    assign store_wr = acc ? wr_en : '0;

    dbrr_name_store #(
        .NAME_MAX (NAME_MAX)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_row  (wr_row),
        .i_wr_data (wr_data),
        .i_rd_row  (rd_row),
        .o_rd_data (rd_data)
    );

    logic [Q_W-1:0] word_base;
    logic [Q_W-1:0] name_start;

    assign word_base  = Q_W'({r_word, 3'b000});
    // may wrap negative on the first answer beat; those lanes are masked
    assign name_start = word_base - Q_W'(r_n0);

    always_comb begin
        logic [2:0]     off;
        logic [Q_W-1:0] x;
        for (int g = 0; g < LANES; g++) begin
            off       = 3'(g) - name_start[2:0];
            x         = name_start + Q_W'(off);
            rd_row[g] = x[ROW_W+2:3];
        end
    end

    logic [Q_W-1:0]              rem;
    logic                        emit_final;
    logic [3:0]                  emit_count;
    dbrr_pkg::t_byte [LANES-1:0] emit_bytes;
    logic [Q_W-1:0]              name_end;

    assign rem        = Q_W'(r_total) - word_base;
    assign emit_final = rem <= Q_W'(LANES);
    assign emit_count = emit_final ? rem[3:0] : 4'd8;
    assign name_end   = Q_W'(r_n0) + Q_W'(r_alen);

    always_comb begin
        logic [Q_W-1:0] q;
        logic [Q_W-1:0] t;
        for (int j = 0; j < LANES; j++) begin
            q = word_base + Q_W'(j);
            t = q - name_end;
            if (q < Q_W'(r_n0)) begin
                emit_bytes[j] = r_held[q[2:0]];
            end else if (q < name_end) begin
                emit_bytes[j] = rd_data[3'(j) - r_n0[2:0]];
            end else if (q < Q_W'(r_total)) begin
                emit_bytes[j] = dbrr_pkg::tail_byte(t[3:0], r_addr);
            end else begin
                emit_bytes[j] = 8'h00;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    logic go_append;
    logic out_load;

    assign go_append = i_req.last_word && (r_mode == dbrr_pkg::MODE_FAKE) && n_done;
    assign out_load  = ((r_state == S_PASS) && acc && !go_append)
                       || ((r_state == S_EMIT) && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PASS;
            r_pos       <= '0;
            r_len       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_PASS: begin
                    if (acc) begin
                        if (i_req.last_word) begin
                            r_pos  <= '0;
                            r_len  <= '0;
                            r_done <= 1'b0;
                        end else begin
                            r_pos  <= n_pos;
                            r_len  <= n_len;
                            r_done <= n_done;
                        end
                        if (go_append) begin
                            r_held  <= beat_bytes;
                            r_n0    <= cnt;
                            r_alen  <= n_len;
                            r_total <= TOT_W'(cnt) + TOT_W'(n_len)
                                       + TOT_W'(dbrr_pkg::TAIL_LEN);
                            r_word  <= '0;
                            r_state <= S_READ;
                        end else begin
                            r_out.out_word   <= beat_bytes;
                            r_out.out_count  <= cnt;
                            r_out.out_last   <= i_req.last_word;
                            r_out.name_error <= i_req.last_word
                                                && (r_mode == dbrr_pkg::MODE_FAKE)
                                                && !n_done;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.out_word   <= emit_bytes;
                        r_out.out_count  <= emit_count;
                        r_out.out_last   <= emit_final;
                        r_out.name_error <= 1'b0;
                        r_word           <= r_word + WRD_W'(1);
                        r_state          <= emit_final ? S_PASS : S_READ;
                    end
                end
                default: r_state <= S_PASS;
            endcase
        end
    end

endmodule

### sv/dbrr_name_store.sv
// ============================================================================
// dbrr_name_store - banked query name store
// Eight byte-wide banks, bank = name index mod 8, so any eight consecutive
// name bytes hit each bank once. One write and one registered read per bank.
// ============================================================================
module dbrr_name_store #(
    parameter  int NAME_MAX = dbrr_pkg::NAME_MAX_DEF,
    localparam int ROWS     = (NAME_MAX + 7) / 8,
    localparam int ROW_W    = $clog2(ROWS),
    localparam int DEPTH    = 2 ** ROW_W
) (
    input  logic                                        i_clk,
    input  logic [dbrr_pkg::LANES-1:0]                  i_wr_en,
    input  logic [dbrr_pkg::LANES-1:0][ROW_W-1:0]       i_wr_row,
    input  dbrr_pkg::t_byte [dbrr_pkg::LANES-1:0]       i_wr_data,
    input  logic [dbrr_pkg::LANES-1:0][ROW_W-1:0]       i_rd_row,
    output dbrr_pkg::t_byte [dbrr_pkg::LANES-1:0]       o_rd_data
);

    for (genvar g = 0; g < dbrr_pkg::LANES; g++) begin : g_bank
        dbrr_pkg::t_byte mem [DEPTH];
        dbrr_pkg::t_byte r_rd;

        always_ff @(posedge i_clk) begin
            if (i_wr_en[g]) begin
                mem[i_wr_row[g]] <= i_wr_data[g];
            end
            r_rd <= mem[i_rd_row[g]];
        end

        assign o_rd_data[g] = r_rd;
    end

endmodule

### sv/dbrr_checker.sv
// ============================================================================
// dbrr_checker - port-level checks for the DNS response rewriter
// Watches the response channel; attached to the top level by bind.
// ============================================================================
module dbrr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input dbrr_pkg::t_rsp o_rsp
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("response beat changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.name_error |-> o_rsp.out_last)
        else $error("name_error on a beat that is not last");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.out_count != 4'd0) && (o_rsp.out_count <= 4'd8))
        else $error("out_count outside 1..8");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_rsp.out_word >> {o_rsp.out_count, 3'b000}) == 64'd0))
        else $error("bytes beyond out_count not zero");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid right after reset");

endmodule

bind dns_block_response_rewriter dbrr_checker u_dbrr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);
